// ----- design/assert_macros.svh -----
// assertion macros shared by the sharpening block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define RCKS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// condition that must be followed by another in the next cycle
`define RCKS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");
`else
`define RCKS_ASSERT(lbl, clk, rst, prop)
`define RCKS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- design/rcks_pkg.sv -----
// shared types, constants and kernel arithmetic for the cross-kernel sharpener
`timescale 1ns / 1ps
`default_nettype none

package rcks_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int RSP_CNT_W = 4;

   typedef struct packed {
      logic [7:0]  ch0;
      logic [7:0]  ch1;
      logic [7:0]  ch2;
      logic [15:0] row;
      logic [10:0] col;
      logic        last;
   } rsp_beat_type;

   // queue writes for one cycle, second only together with first
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // 5*centre minus the four neighbours, saturated to one byte
   function automatic logic [7:0] sharpen_chan(input logic [7:0] ctr,
                                               input logic [7:0] lt,
                                               input logic [7:0] rt,
                                               input logic [7:0] up,
                                               input logic [7:0] dn);
      logic signed [11:0] acc;
      logic [7:0]         res;
      acc = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
          - $signed({4'b0000, lt}) - $signed({4'b0000, rt})
          - $signed({4'b0000, up}) - $signed({4'b0000, dn});
      if (acc < 0) begin
         res = 8'h00;
      end else if (acc > 12'sd255) begin
         res = 8'hFF;
      end else begin
         res = acc[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/rcks_rsp_fifo.sv -----
// result queue: takes up to two beats a cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rcks_rsp_fifo (
   input  wire                             clock,
   input  wire                             reset,
   input  rcks_pkg::push_type              push,
   input  rcks_pkg::rsp_beat_type          data_a,
   input  rcks_pkg::rsp_beat_type          data_b,
   input  wire                             pop,
   output logic [rcks_pkg::RSP_CNT_W-1:0]  level,
   output rcks_pkg::rsp_beat_type          head
);

   rcks_pkg::rsp_beat_type entries_ff [rcks_pkg::RSP_DEPTH];

   logic [rcks_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rcks_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rcks_pkg::RSP_CNT_W-1:0] level_ff, level_in;
   logic [rcks_pkg::RSP_PTR_W-1:0] wr_next;
   logic [1:0]                     push_n;
   logic [rcks_pkg::RSP_CNT_W-1:0] level_peak;

   always_comb begin
      push_n     = {1'b0, push.first} + {1'b0, push.second};
      wr_next    = wr_ptr_ff + rcks_pkg::RSP_PTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + rcks_pkg::RSP_PTR_W'(push_n);
      rd_ptr_in  = rd_ptr_ff + rcks_pkg::RSP_PTR_W'(pop);
      level_peak = level_ff + rcks_pkg::RSP_CNT_W'(push_n);
      level_in   = level_peak - rcks_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entries_ff[wr_ptr_ff] <= data_a;
      end
      if (push.second) begin
         entries_ff[wr_next] <= data_b;
      end
   end

   assign level = level_ff;
   assign head  = entries_ff[rd_ptr_ff];

   `RCKS_ASSERT(a_push_order, clock, reset, !push.second || push.first)
   `RCKS_ASSERT(a_no_overflow, clock, reset,
                level_peak <= rcks_pkg::RSP_CNT_W'(rcks_pkg::RSP_DEPTH))
   `RCKS_ASSERT(a_ptr_level, clock, reset,
                (wr_ptr_ff - rd_ptr_ff) == level_ff[rcks_pkg::RSP_PTR_W-1:0])

endmodule

`default_nettype wire

// ----- design/rgb_cross_kernel_sharpen_top.sv -----
// top level of the three-channel cross-kernel sharpening filter
//
// Pixels enter in raster order on the req_ channel, one beat per pixel,
// and sharpened pixels leave on the rsp_ channel tagged with row and
// column. A beat on row r >= 1 produces the result for (r-1, c); a beat
// on the last row also produces the zero pixel (r, c), flagged run_last.
// Beats of the first row fill the line stores and produce nothing.
// On its way out a result passes the read-data and second-stage
// registers and is then written into the result queue, whose head drives rsp_.
// Throughput: one pixel per cycle while req_stall is low, set by the
// single read-modify-write pass through the two line stores (middle
// row read at two columns); on the last row each pixel makes two
// results, so there req_stall holds intake back once the queue fills.
// An eight-entry result queue sits before rsp_, so a stalled receiver
// does not hold up intake until the queue is close to full; req_stall
// then rises. Nothing is lost or repeated while rsp_stall is high.
// Reset clears the row and column counters and loads frame_width 640
// and frame_height 480; the line stores are not cleared, the first row
// of every frame writes them before any result reads them.
// A csr_ write to frame_width or frame_height restarts the frame; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_cross_kernel_sharpen_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write,
   input  wire  [rcks_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [rcks_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [7:0]                       req_pixel_ch0,
   input  wire  [7:0]                       req_pixel_ch1,
   input  wire  [7:0]                       req_pixel_ch2,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [7:0]                       rsp_out_ch0,
   output logic [7:0]                       rsp_out_ch1,
   output logic [7:0]                       rsp_out_ch2,
   output logic [15:0]                      rsp_out_row,
   output logic [10:0]                      rsp_out_col,
   output logic                             rsp_run_last
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = (COL_W + 1 > 12) ? COL_W + 1 : 12;

   // configuration
   logic [11:0] frame_width_ff;
   logic [15:0] frame_height_ff;

   // position of the next pixel
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      row_ff, row_in;

   // line stores
   logic [23:0] line_above_ff  [MAX_WIDTH];
   logic [23:0] line_middle_ff [MAX_WIDTH];

   // registered read data
   logic [23:0] above_up_ff;
   logic [23:0] mid_ctr_ff;
   logic [23:0] mid_right_ff;
   logic [23:0] prev_ctr_ff;

   // second stage
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [15:0]      s1_row_ff;
   logic [23:0]      s1_px_ff;
   logic             s1_emit_ff;
   logic             s1_lastrow_ff;
   logic             s1_inner_ff;

   logic              accept;
   logic [23:0]       pixel;
   logic [WW+11:0]    fw_wide;
   logic [WW+COL_W-1:0] col_wide;
   logic [WW-1:0]     fw_ext;
   logic [WW-1:0]     col_ext;
   logic [WW-1:0]     eff_w;
   logic [WW-1:0]     eff_w_m1;
   logic [15:0]       eff_h_m1;
   logic              at_last_col;
   logic              at_last_row;
   logic [COL_W-1:0]  col_right;
   logic [1:0]        pending;
   logic [rcks_pkg::RSP_CNT_W-1:0] need;
   logic [rcks_pkg::RSP_CNT_W-1:0] level;
   logic              pop;
   logic [COL_W+10:0] out_col_wide;
   logic [7:0]        sh0, sh1, sh2;

   rcks_pkg::push_type     push;
   rcks_pkg::rsp_beat_type beat_a;
   rcks_pkg::rsp_beat_type beat_b;
   rcks_pkg::rsp_beat_type head;

   // geometry and intake control
   always_comb begin
      pixel       = {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
      fw_wide     = {{WW{1'b0}}, frame_width_ff};
      fw_ext      = fw_wide[WW-1:0];
      col_wide    = {{WW{1'b0}}, col_ff};
      col_ext     = col_wide[WW-1:0];
      if (fw_ext < WW'(3)) begin
         eff_w = WW'(3);
      end else if (fw_ext > WW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      eff_w_m1    = eff_w - WW'(1);
      eff_h_m1    = ((frame_height_ff < 16'd3) ? 16'd3 : frame_height_ff) - 16'd1;
      at_last_col = (col_ext == eff_w_m1);
      at_last_row = (row_ff == eff_h_m1);
      col_right   = col_ff + COL_W'(1);

      pending = s1_valid_ff ? ({1'b0, s1_emit_ff} + {1'b0, s1_lastrow_ff}) : 2'd0;
      need    = level + rcks_pkg::RSP_CNT_W'(pending) + rcks_pkg::RSP_CNT_W'(2);
      // room for what is in flight plus the worst case of the new pixel
      req_stall = (need > rcks_pkg::RSP_CNT_W'(rcks_pkg::RSP_DEPTH));
      accept    = req_valid && !req_stall;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd640;
         frame_height_ff <= 16'd480;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rcks_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[11:0];
               col_ff         <= '0;
               row_ff         <= '0;
            end
            rcks_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata;
               col_ff          <= '0;
               row_ff          <= '0;
            end
            default: begin
               col_ff <= col_in;
               row_ff <= row_in;
            end
         endcase
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // middle row: read centre and right, write the new pixel in its place
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ctr_ff            <= line_middle_ff[col_ff];
         mid_right_ff          <= line_middle_ff[col_right];
         line_middle_ff[col_ff] <= pixel;
      end
   end

   // upper row: read at intake, centre is moved up from the second stage
   always_ff @(posedge clock) begin
      if (accept) begin
         above_up_ff <= line_above_ff[col_ff];
      end
      if (s1_valid_ff) begin
         line_above_ff[s1_col_ff] <= mid_ctr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_px_ff      <= pixel;
         s1_emit_ff    <= (row_ff != 16'd0);
         s1_lastrow_ff <= at_last_row;
         s1_inner_ff   <= (row_ff > 16'd1) && (col_ff != '0) && !at_last_col;
      end
      // centre of this pixel is the left neighbour of the next one
      if (s1_valid_ff) begin
         prev_ctr_ff <= mid_ctr_ff;
      end
   end

   // kernel and result beats
   always_comb begin
      sh0 = rcks_pkg::sharpen_chan(mid_ctr_ff[7:0], prev_ctr_ff[7:0],
                                   mid_right_ff[7:0], above_up_ff[7:0], s1_px_ff[7:0]);
      sh1 = rcks_pkg::sharpen_chan(mid_ctr_ff[15:8], prev_ctr_ff[15:8],
                                   mid_right_ff[15:8], above_up_ff[15:8], s1_px_ff[15:8]);
      sh2 = rcks_pkg::sharpen_chan(mid_ctr_ff[23:16], prev_ctr_ff[23:16],
                                   mid_right_ff[23:16], above_up_ff[23:16],
                                   s1_px_ff[23:16]);
      out_col_wide = {11'b0, s1_col_ff};

      beat_a.ch0  = s1_inner_ff ? sh0 : 8'h00;
      beat_a.ch1  = s1_inner_ff ? sh1 : 8'h00;
      beat_a.ch2  = s1_inner_ff ? sh2 : 8'h00;
      beat_a.row  = s1_row_ff - 16'd1;
      beat_a.col  = out_col_wide[10:0];
      beat_a.last = !s1_lastrow_ff;

      beat_b.ch0  = 8'h00;
      beat_b.ch1  = 8'h00;
      beat_b.ch2  = 8'h00;
      beat_b.row  = s1_row_ff;
      beat_b.col  = out_col_wide[10:0];
      beat_b.last = 1'b1;

      push.first  = s1_valid_ff && s1_emit_ff;
      push.second = s1_valid_ff && s1_lastrow_ff;
   end

   rcks_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .data_a (beat_a),
      .data_b (beat_b),
      .pop    (pop),
      .level  (level),
      .head   (head)
   );

   assign rsp_valid    = (level != '0);
   assign pop          = rsp_valid && !rsp_stall;
   assign rsp_out_ch0  = head.ch0;
   assign rsp_out_ch1  = head.ch1;
   assign rsp_out_ch2  = head.ch2;
   assign rsp_out_row  = head.row;
   assign rsp_out_col  = head.col;
   assign rsp_run_last = head.last;

   `RCKS_ASSERT_NEXT(a_accept_stage, clock, reset, accept, s1_valid_ff)
   `RCKS_ASSERT(a_inner_emits, clock, reset, !s1_inner_ff || s1_emit_ff || !s1_valid_ff)
   `RCKS_ASSERT_NEXT(a_col_wrap, clock, reset, accept && at_last_col, col_ff == '0)

endmodule

`default_nettype wire
